// ----- sv/gffvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffvc_pkg
// shared types and constants of the greedy first-fit vertex colorer
// ----------------------------------------------------------------------------
package gffvc_pkg;

  localparam int MAX_COLORS_DEF   = 128;
  localparam int VERTEX_COUNT_DEF = 65536;
  localparam int ID_W             = 16;
  localparam int COLOR_OUT_W      = 7;
  localparam int STORE_W          = 8;
  localparam logic [STORE_W-1:0] STORE_UNCOLORED = 8'hFF;
  localparam int GROUP_W          = 16;
  localparam int Q_DEPTH          = 2;

  typedef enum logic {
    K_ADJ   = 1'b0,
    K_CLEAR = 1'b1
  } kind_e;

  typedef enum logic {
    ST_SWEEP = 1'b0,
    ST_RUN   = 1'b1
  } state_e;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] vid;
    logic [ID_W-1:0] nid;
    logic            mark;
    logic            last;
    logic            vid_ok;
  } q_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]        vid;
    logic [COLOR_OUT_W-1:0] color;
    logic [COLOR_OUT_W-1:0] highest;
    logic                   overflow;
  } res_t;

endpackage

// ----- sv/gffvc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffvc_front
// accepts requests, classifies them and pushes them into the queue
// ----------------------------------------------------------------------------
module gffvc_front import gffvc_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            command_i,
  input  logic [ID_W-1:0] vertex_id_i,
  input  logic [ID_W-1:0] neighbor_id_i,
  input  logic            has_neighbor_i,
  input  logic            last_neighbor_i,
  input  logic            full_i,
  output logic            push_o,
  output q_entry_t        entry_o
);

  logic     valid_q, valid_d;
  q_entry_t entry_q, entry_d;
  logic     vid_ok, nid_ok;
  logic     accept;

  assign vid_ok     = 32'(vertex_id_i) < 32'(VERTEX_COUNT);
  assign nid_ok     = 32'(neighbor_id_i) < 32'(VERTEX_COUNT);
  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign entry_o    = entry_q;

  always_comb begin
    entry_d.kind   = command_i ? K_CLEAR : K_ADJ;
    entry_d.vid    = vertex_id_i;
    entry_d.nid    = neighbor_id_i;
    entry_d.mark   = !command_i && has_neighbor_i && nid_ok &&
                     (neighbor_id_i != vertex_id_i);
    entry_d.last   = !command_i && last_neighbor_i;
    entry_d.vid_ok = vid_ok;
    valid_d        = accept ? 1'b1 : (push_o ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

// ----- sv/gffvc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffvc_fifo
// short request queue between front and back
// ----------------------------------------------------------------------------
module gffvc_fifo import gffvc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output q_entry_t head_o
);

  localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CntW = $clog2(Q_DEPTH + 1);

  q_entry_t            mem_q [Q_DEPTH];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- sv/gffvc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffvc_back
// color store, neighbor marking, first-fit pick and store clearing sweep
// ----------------------------------------------------------------------------
module gffvc_back import gffvc_pkg::*; #(
  parameter int MAX_COLORS   = MAX_COLORS_DEF,
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  q_entry_t q_head_i,
  output logic     q_pop_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output res_t     res_o
);

  localparam int IdxW   = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int ColW   = $clog2(MAX_COLORS);
  localparam int NumGrp = (MAX_COLORS + GROUP_W - 1) / GROUP_W;
  localparam int PadW   = NumGrp * GROUP_W;
  localparam int GrpW   = (NumGrp > 1) ? $clog2(NumGrp) : 1;
  localparam int LowW   = $clog2(GROUP_W);

  typedef struct packed {
    logic               en;
    logic [ID_W-1:0]    vid;
    logic [STORE_W-1:0] data;
  } wr_t;

  // color store
  logic [STORE_W-1:0] store_mem [VERTEX_COUNT];
  logic [STORE_W-1:0] rdata_q;
  logic               mem_we;
  logic [IdxW-1:0]    mem_wa, mem_ra;
  logic [STORE_W-1:0] mem_wd;
  logic [31:0]        wvid32, nid32;

  // sweep control
  state_e          st_q, st_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  // mark stage
  logic               s1_valid_q, s1_valid_d;
  q_entry_t           s1_q;
  logic               s1_fresh_q;
  logic [STORE_W-1:0] s1_col_q;
  logic [STORE_W-1:0] col_src, col_fwd;
  logic               colored, mark_en, hazard;
  logic [31:0]        col32;
  logic [MAX_COLORS-1:0] map_q, map_d, new_map;
  logic [PadW-1:0]    pm;
  logic [NumGrp-1:0]  full_d;
  logic [LowW-1:0]    low_d [NumGrp];
  logic               s1_fire, s1_free;

  // pick stage
  logic               s2_valid_q, s2_valid_d;
  logic [ID_W-1:0]    s2_vid_q;
  logic               s2_vid_ok_q;
  logic [NumGrp-1:0]  s2_full_q;
  logic [LowW-1:0]    s2_low_q [NumGrp];
  logic               found;
  logic [GrpW-1:0]    pick_grp;
  logic [LowW-1:0]    pick_low;
  logic [ColW-1:0]    pick, max_new;
  logic [ColW-1:0]    max_q, max_d;
  logic [31:0]        pick32, max32;
  logic               s2_fire, s2_go;

  // write register and the one before it
  wr_t w_q, w_d, wp_q;

  // result register
  logic out_valid_q, out_valid_d;
  res_t out_q, out_d;
  logic out_load_ok;

  logic pipe_empty, pop_adj, pop_clr;

  assign out_load_ok = !out_valid_q || res_ready_i;
  assign s2_fire     = s2_valid_q && out_load_ok;
  assign s2_go       = !s2_valid_q || out_load_ok;
  assign pipe_empty  = !s1_valid_q && !s2_valid_q && !w_q.en;

  // forwarding of colors not yet in the store
  always_comb begin
    col_src = s1_fresh_q ? rdata_q : s1_col_q;
    col_fwd = col_src;
    if (wp_q.en && (wp_q.vid == s1_q.nid)) begin
      col_fwd = wp_q.data;
    end
    if (w_q.en && (w_q.vid == s1_q.nid)) begin
      col_fwd = w_q.data;
    end
  end

  assign hazard  = s1_valid_q && s1_q.mark && s2_valid_q && (s2_vid_q == s1_q.nid);
  assign col32   = 32'(col_fwd);
  assign colored = (col_fwd != STORE_UNCOLORED) && (col32 < 32'(MAX_COLORS));
  assign mark_en = s1_q.mark && colored;
  assign s1_fire = s1_valid_q && !hazard && (!s1_q.last || s2_go);
  assign s1_free = !s1_valid_q || s1_fire;

  assign pop_adj = (st_q == ST_RUN) && q_valid_i && (q_head_i.kind == K_ADJ) && s1_free;
  assign pop_clr = (st_q == ST_RUN) && q_valid_i && (q_head_i.kind == K_CLEAR) &&
                   pipe_empty;
  assign q_pop_o = pop_adj || pop_clr;

  always_comb begin
    new_map = map_q;
    if (mark_en) begin
      new_map[col32[ColW-1:0]] = 1'b1;
    end
    pm                   = '1;
    pm[MAX_COLORS-1:0]   = new_map;
  end

  // per-group first free color
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      full_d[g] = &pm[g*GROUP_W +: GROUP_W];
      low_d[g]  = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
        if (!pm[g*GROUP_W + i]) begin
          low_d[g] = LowW'(i);
        end
      end
    end
  end

  // first group with a free color
  always_comb begin
    found    = 1'b0;
    pick_grp = '0;
    pick_low = '0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (!s2_full_q[g]) begin
        found    = 1'b1;
        pick_grp = GrpW'(g);
        pick_low = s2_low_q[g];
      end
    end
    pick32  = 32'({pick_grp, pick_low});
    pick    = pick32[ColW-1:0];
    max_new = (found && (pick > max_q)) ? pick : max_q;
    max32   = 32'(max_new);
  end

  always_comb begin
    s1_valid_d = pop_adj ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    s2_valid_d = (s1_fire && s1_q.last) ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_q);
    out_valid_d = s2_fire ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);

    map_d = map_q;
    if (pop_clr) begin
      map_d = '0;
    end else if (s1_fire) begin
      map_d = s1_q.last ? '0 : new_map;
    end

    max_d = pop_clr ? '0 : (s2_fire ? max_new : max_q);

    w_d.en   = s2_fire && s2_vid_ok_q;
    w_d.vid  = s2_vid_q;
    w_d.data = found ? pick32[STORE_W-1:0] : STORE_UNCOLORED;

    out_d.vid      = s2_vid_q;
    out_d.color    = found ? pick32[COLOR_OUT_W-1:0] : '0;
    out_d.highest  = max32[COLOR_OUT_W-1:0];
    out_d.overflow = !found;
  end

  // sweep state machine
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    unique case (st_q)
      ST_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IdxW'(VERTEX_COUNT - 1)) begin
          st_d  = ST_RUN;
          cnt_d = '0;
        end
      end
      ST_RUN: begin
        if (pop_clr) begin
          st_d  = ST_SWEEP;
          cnt_d = '0;
        end
      end
      default: begin
        st_d  = ST_SWEEP;
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_SWEEP;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      map_q       <= '0;
      max_q       <= '0;
      w_q         <= '0;
      wp_q        <= '0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      map_q       <= map_d;
      max_q       <= max_d;
      w_q         <= w_d;
      wp_q        <= w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_adj) begin
      s1_q       <= q_head_i;
      s1_fresh_q <= 1'b1;
    end else if (s1_valid_q && !s1_fire) begin
      s1_col_q   <= col_fwd;
      s1_fresh_q <= 1'b0;
    end
    if (s1_fire && s1_q.last) begin
      s2_vid_q    <= s1_q.vid;
      s2_vid_ok_q <= s1_q.vid_ok;
      s2_full_q   <= full_d;
      s2_low_q    <= low_d;
    end
    if (s2_fire) begin
      out_q <= out_d;
    end
  end

  assign wvid32 = 32'(w_q.vid);
  assign nid32  = 32'(q_head_i.nid);
  assign mem_we = (st_q == ST_SWEEP) || w_q.en;
  assign mem_wa = (st_q == ST_SWEEP) ? cnt_q : wvid32[IdxW-1:0];
  assign mem_wd = (st_q == ST_SWEEP) ? STORE_UNCOLORED : w_q.data;
  assign mem_ra = nid32[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    if (pop_adj) begin
      rdata_q <= store_mem[mem_ra];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef SYNTH
  a_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SWEEP) |-> (!s1_valid_q && !s2_valid_q && !w_q.en))
    else $error("pipeline busy during store sweep");

  a_pick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_valid_q && !res_ready_i) |=> s2_valid_q)
    else $error("pick stage lost while result blocked");

  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_clr |=> ((st_q == ST_SWEEP) && (map_q == '0) && (max_q == '0)))
    else $error("clear request did not start sweep");

  a_no_stale_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.last) |=> (map_q == '0))
    else $error("color bitmap not cleared after vertex");
`endif

endmodule

// ----- sv/greedy_first_fit_vertex_coloring.sv -----
// path of a result: front register, queue, mark stage, pick stage, result register
// throughput: one request per cycle while nothing stalls; a neighbor that is the vertex
//   whose color pick is still in flight holds the mark stage until that pick moves on
// reset: the color store is swept to uncolored, one entry per cycle, after reset and
//   after each clear request; the queue is not drained meanwhile
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_first_fit_vertex_coloring
// serial greedy first-fit graph coloring over streamed adjacency lists
// ----------------------------------------------------------------------------
module greedy_first_fit_vertex_coloring import gffvc_pkg::*; #(
  parameter int MAX_COLORS   = MAX_COLORS_DEF,
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   command_i,
  input  logic [ID_W-1:0]        vertex_id_i,
  input  logic [ID_W-1:0]        neighbor_id_i,
  input  logic                   has_neighbor_i,
  input  logic                   last_neighbor_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ID_W-1:0]        colored_vertex_o,
  output logic [COLOR_OUT_W-1:0] assigned_color_o,
  output logic [COLOR_OUT_W-1:0] highest_color_o,
  output logic                   color_overflow_o
);

  logic     push, full, q_valid, q_pop;
  q_entry_t push_entry, head;
  res_t     res;

  gffvc_front #(
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .vertex_id_i    (vertex_id_i),
    .neighbor_id_i  (neighbor_id_i),
    .has_neighbor_i (has_neighbor_i),
    .last_neighbor_i(last_neighbor_i),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  gffvc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .head_o (head)
  );

  gffvc_back #(
    .MAX_COLORS  (MAX_COLORS),
    .VERTEX_COUNT(VERTEX_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (head),
    .q_pop_o    (q_pop),
    .res_valid_o(out_valid_o),
    .res_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign colored_vertex_o = res.vid;
  assign assigned_color_o = res.color;
  assign highest_color_o  = res.highest;
  assign color_overflow_o = res.overflow;

endmodule

// ----- tb/sv/tb_greedy_first_fit_vertex_coloring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_first_fit_vertex_coloring
// self-checking bench for the streamed greedy first-fit vertex colorer: a
// short table of directed requests, three phases of random adjacency lists
// with varied idling on both channels and a clear in each, then a 33-vertex
// clique that climbs to color 32. every result is checked field by field
// against an in-bench first-fit predictor or the table's expected fields.
// ----------------------------------------------------------------------------
module tb_greedy_first_fit_vertex_coloring;
  import gffvc_pkg::*;

  localparam int NCOL    = MAX_COLORS_DEF;
  localparam int NVERT   = VERTEX_COUNT_DEF;
  localparam int QUOTA   = 285;
  localparam int CLQ     = 32;
  localparam int TAIL    = 20;

  typedef struct {
    kind_e           kind;
    logic [ID_W-1:0] vid;
    logic [ID_W-1:0] nid;
    logic            has;
    logic            last;
    bit              typed;
    res_t            want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   command_i = 1'b0;
  logic [ID_W-1:0]        vertex_id_i = '0;
  logic [ID_W-1:0]        neighbor_id_i = '0;
  logic                   has_neighbor_i = 1'b0;
  logic                   last_neighbor_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [ID_W-1:0]        colored_vertex_o;
  logic [COLOR_OUT_W-1:0] assigned_color_o;
  logic [COLOR_OUT_W-1:0] highest_color_o;
  logic                   color_overflow_o;

  // predictor state
  logic [STORE_W-1:0]     color_tab [NVERT];
  logic [NCOL-1:0]        used_map;
  logic [COLOR_OUT_W-1:0] top_color;

  res_t     due_colorings [$];
  dir_row_t dir_rows [$];
  res_t     head;
  int       snd_idle = 12;
  int       rcv_idle = 74;
  int       errs = 0;
  int       n_items = 0;
  int       n_results = 0;
  int       n_clears = 0;
  int       n_overflow = 0;
  logic [ID_W-1:0] pool_lo = '0;

  greedy_first_fit_vertex_coloring uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .vertex_id_i      (vertex_id_i),
    .neighbor_id_i    (neighbor_id_i),
    .has_neighbor_i   (has_neighbor_i),
    .last_neighbor_i  (last_neighbor_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .colored_vertex_o (colored_vertex_o),
    .assigned_color_o (assigned_color_o),
    .highest_color_o  (highest_color_o),
    .color_overflow_o (color_overflow_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    errs++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // first-fit color pick for one accepted request
  function automatic bit first_fit_pick(input kind_e k, input logic [ID_W-1:0] v,
                                        input logic [ID_W-1:0] n, input logic h,
                                        input logic l, output res_t r);
    logic [STORE_W-1:0] c;
    int pick;
    bit found;
    r = '0;
    pick = 0;
    if (k == K_CLEAR) begin
      for (int i = 0; i < NVERT; i++) color_tab[i] = STORE_UNCOLORED;
      used_map = '0;
      top_color = '0;
      return 1'b0;
    end
    if (h && n != v) begin
      c = color_tab[n];
      if (c != STORE_UNCOLORED && c < NCOL) used_map[c] = 1'b1;
    end
    if (!l) return 1'b0;
    found = ~&used_map;
    for (int i = NCOL - 1; i >= 0; i--) if (!used_map[i]) pick = i;
    if (found) begin
      color_tab[v] = STORE_W'(pick);
      if (pick > top_color) top_color = COLOR_OUT_W'(pick);
    end else begin
      color_tab[v] = STORE_UNCOLORED;
    end
    used_map = '0;
    r.vid = v;
    r.color = found ? COLOR_OUT_W'(pick) : '0;
    r.highest = top_color;
    r.overflow = !found;
    return 1'b1;
  endfunction

  // drive one request and wait for it to be taken; called at a rising edge
  task automatic push_req(input kind_e k, input logic [ID_W-1:0] v, input logic [ID_W-1:0] n,
                          input logic h, input logic l, input bit typed, input res_t want);
    res_t r;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= k;
    vertex_id_i     <= v;
    neighbor_id_i   <= n;
    has_neighbor_i  <= h;
    last_neighbor_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    if (k == K_CLEAR) n_clears++;
    if (first_fit_pick(k, v, n, h, l, r)) begin
      if (typed) r = want;
      if (r.overflow) n_overflow++;
      due_colorings.push_back(r);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_colorings.size() != 0);
  endtask

  task automatic add_row(input kind_e k, input logic [ID_W-1:0] v, input logic [ID_W-1:0] n,
                         input logic h, input logic l, input bit t,
                         input logic [ID_W-1:0] wv, input logic [COLOR_OUT_W-1:0] wc,
                         input logic [COLOR_OUT_W-1:0] wh, input logic wo);
    dir_row_t row;
    row.kind = k;
    row.vid = v;
    row.nid = n;
    row.has = h;
    row.last = l;
    row.typed = t;
    row.want.vid = wv;
    row.want.color = wc;
    row.want.highest = wh;
    row.want.overflow = wo;
    dir_rows.push_back(row);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 8) return pool_lo + ID_W'($urandom_range(0, 63));
    return ID_W'($urandom);
  endfunction

  // one adjacency list, mostly well formed
  task automatic send_vertex();
    logic [ID_W-1:0] v;
    logic [ID_W-1:0] n;
    logic h;
    int cnt;
    int r;
    int r2;
    v = pick_id();
    r = $urandom_range(0, 19);
    if (r == 0) begin
      // noise
      cnt = $urandom_range(1, 6);
      for (int i = 0; i < cnt; i++)
        push_req(K_ADJ, ID_W'($urandom), ID_W'($urandom), 1'($urandom), 1'($urandom), 0, '0);
      return;
    end
    cnt = (r == 1) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    if (cnt == 0) begin
      push_req(K_ADJ, v, ID_W'($urandom), 1'b0, 1'b1, 0, '0);
      return;
    end
    for (int i = 0; i < cnt; i++) begin
      r2 = $urandom_range(0, 9);
      n = pick_id();
      h = 1'b1;
      if (r2 == 0) begin
        n = v;
      end else if (r2 == 1) begin
        h = 1'b0;
        n = ID_W'($urandom);
      end
      // r == 2: list left open, its marks carry into the next vertex
      push_req(K_ADJ, v, n, h, (i == cnt - 1) && (r != 2), 0, '0);
    end
  endtask

  task automatic run_phase(input int snd, input int rcv);
    int start;
    bit mid_done;
    snd_idle = snd;
    rcv_idle = rcv;
    pool_lo = ID_W'($urandom);
    start = n_items;
    mid_done = 0;
    while (n_items - start < QUOTA) begin
      send_vertex();
      if (!mid_done && n_items - start >= QUOTA / 2) begin
        wait_drain();
        push_req(K_CLEAR, ID_W'($urandom), ID_W'($urandom), 1'($urandom), 1'($urandom), 0, '0);
        mid_done = 1;
        pool_lo = ID_W'($urandom);
      end else if ($urandom_range(0, 99) == 0) begin
        wait_drain();
      end
    end
    wait_drain();
  endtask

  // vertex base+k is adjacent to base+0..base+k-1, so it takes color k;
  // one more vertex hanging off the top then takes color 0
  task automatic build_clique(input logic [ID_W-1:0] base);
    push_req(K_ADJ, base, '0, 1'b0, 1'b1, 0, '0);
    for (int k = 1; k <= CLQ; k++)
      for (int j = 0; j < k; j++)
        push_req(K_ADJ, base + ID_W'(k), base + ID_W'(j), 1'b1, j == k - 1, 0, '0);
    push_req(K_ADJ, base + ID_W'(CLQ + 1), base + ID_W'(CLQ), 1'b1, 1'b1, 0, '0);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_colorings.size() == 0) begin
        flag("unexpected result, vertex", 32'(colored_vertex_o), '0);
      end else begin
        head = due_colorings.pop_front();
        n_results++;
        if (colored_vertex_o !== head.vid)
          flag("colored_vertex", 32'(colored_vertex_o), 32'(head.vid));
        if (assigned_color_o !== head.color)
          flag("assigned_color", 32'(assigned_color_o), 32'(head.color));
        if (highest_color_o !== head.highest)
          flag("highest_color", 32'(highest_color_o), 32'(head.highest));
        if (color_overflow_o !== head.overflow)
          flag("color_overflow", 32'(color_overflow_o), 32'(head.overflow));
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
  end

  initial begin
    #100_000_000;
    $display("timeout: %0d results still due", due_colorings.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < NVERT; i++) color_tab[i] = STORE_UNCOLORED;
    used_map = '0;
    top_color = '0;

    // kind, vertex, neighbor, has, last, typed, expected vertex/color/highest/overflow
    add_row(K_ADJ,   16'h0000, 16'h0000, 1'b0, 1'b1, 1, 16'h0000, 7'd0, 7'd0, 1'b0);
    add_row(K_ADJ,   16'hFFFF, 16'h0000, 1'b1, 1'b1, 1, 16'hFFFF, 7'd1, 7'd1, 1'b0);
    add_row(K_ADJ,   16'h8000, 16'h8000, 1'b1, 1'b1, 1, 16'h8000, 7'd0, 7'd1, 1'b0);
    add_row(K_ADJ,   16'h0005, 16'h0000, 1'b1, 1'b0, 0, '0, '0, '0, 1'b0);
    add_row(K_ADJ,   16'h0005, 16'hFFFF, 1'b1, 1'b0, 0, '0, '0, '0, 1'b0);
    add_row(K_ADJ,   16'h0005, 16'h1234, 1'b1, 1'b0, 0, '0, '0, '0, 1'b0);
    add_row(K_ADJ,   16'h0005, 16'h0000, 1'b0, 1'b1, 0, '0, '0, '0, 1'b0);
    // neighbor whose pick is still in flight
    add_row(K_ADJ,   16'h0006, 16'h0005, 1'b1, 1'b0, 0, '0, '0, '0, 1'b0);
    add_row(K_ADJ,   16'h0006, 16'h0000, 1'b1, 1'b0, 0, '0, '0, '0, 1'b0);
    add_row(K_ADJ,   16'h0006, 16'hFFFF, 1'b1, 1'b0, 0, '0, '0, '0, 1'b0);
    add_row(K_ADJ,   16'h0006, 16'h0006, 1'b1, 1'b1, 0, '0, '0, '0, 1'b0);
    add_row(K_ADJ,   16'h0000, 16'h0006, 1'b1, 1'b1, 0, '0, '0, '0, 1'b0);
    add_row(K_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 0, '0, '0, '0, 1'b0);
    add_row(K_ADJ,   16'h0007, 16'h0005, 1'b1, 1'b1, 1, 16'h0007, 7'd0, 7'd0, 1'b0);
    add_row(K_ADJ,   16'hFFFF, 16'h0007, 1'b1, 1'b1, 1, 16'hFFFF, 7'd1, 7'd1, 1'b0);
    add_row(K_ADJ,   16'h00FF, 16'h0007, 1'b0, 1'b1, 1, 16'h00FF, 7'd0, 7'd1, 1'b0);
    add_row(K_ADJ,   16'h7FFF, 16'hFFFF, 1'b1, 1'b1, 0, '0, '0, '0, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      push_req(dir_rows[i].kind, dir_rows[i].vid, dir_rows[i].nid, dir_rows[i].has,
               dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    wait_drain();

    run_phase(12, 74);
    run_phase(74, 12);
    run_phase(0, 0);
    build_clique(16'h4000);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_colorings.size() != 0);
    repeat (TAIL) @(posedge clk_i);

    $display("covered %0d requests incl. %0d clears; %0d results checked, %0d overflows",
             n_items, n_clears, n_results, n_overflow);
    $display("idle mixes sender/receiver: 12/74, 74/12, none; clique up to color %0d",
             CLQ);
    if (errs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errs);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
